/* rtl/assert_macros.svh */
// assert_macros.svh: concurrent assertion helpers for the DC blocker and limiter.
// No dependencies; the macros use the block's clock and reset port names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPLIES(name, ante, cons, msg)
`define ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

/* rtl/dcsl_pkg.sv */
// dcsl_pkg: types and constants shared by the DC blocker and soft limiter.
// No dependencies; imported by every module of the block.
package dcsl_pkg;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 15;
   localparam int GAIN_W   = 7;
   localparam int LEVEL_W  = 15;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Serial divider of the soft knee: quotient always fits in DIV_Q_W bits.
   localparam int DIV_STEPS = 16;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int DIV_N_W   = 31;
   localparam int DIV_D_W   = 17;
   localparam int DIV_Q_W   = 16;

   // Gain division by one hundred through a reciprocal multiply.
   localparam int                GAIN_DIVISOR = 100;
   localparam logic [21:0]       MAG_CLAMP    = 22'd3276899;
   localparam logic [22:0]       RECIP_MULT   = 23'd5368709;
   localparam int                RECIP_SHIFT  = 29;

   // Register indexes.
   typedef enum logic [1:0] {
      REG_HPF_COEF   = 2'd0,
      REG_HEADROOM   = 2'd1,
      REG_THRESHOLD  = 2'd2,
      REG_FULL_SCALE = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [COEF_W-1:0]  hpf_coef;
      logic [GAIN_W-1:0]  headroom;
      logic [LEVEL_W-1:0] threshold;
      logic [LEVEL_W-1:0] full_scale;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      hpf_coef:   15'd32440,
      headroom:   7'd82,
      threshold:  15'd18000,
      full_scale: 15'd30000
   };

   // One input word after channel resolution.
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                channel;
   } entry_type;

   // One result word.
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_out;
      logic                channel_out;
   } result_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [DIV_Q_W-1:0] quotient;
   } div_rsp_type;

endpackage

/* rtl/dcsl_front.sv */
// dcsl_front: input side; resolves the channel number and feeds the queue.
// Depends on dcsl_pkg.
module dcsl_front
   import dcsl_pkg::*;
#(
   parameter int CHANNELS = 2
) (
   input  logic                push,
   output logic                full,
   input  logic [SAMPLE_W-1:0] sample_in,
   input  logic                channel,
   input  logic                q_full,
   output logic                q_push,
   output entry_type           q_entry
);

   logic ch_sat;

   // A channel beyond the configured count falls onto the last channel.
   always_comb begin
      if (32'(channel) >= CHANNELS) begin
         ch_sat = 1'(CHANNELS - 1);
      end else begin
         ch_sat = channel;
      end
   end

   // Accept whenever the queue has room.
   assign full            = q_full;
   assign q_push          = push && !q_full;
   assign q_entry.sample  = sample_in;
   assign q_entry.channel = ch_sat;

endmodule

/* rtl/dcsl_queue.sv */
// dcsl_queue: short word queue between the front and the back end.
// Depends on dcsl_pkg.
module dcsl_queue
   import dcsl_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output entry_type pop_entry,
   output logic      empty
);

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_entry = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/dcsl_div.sv */
// dcsl_div: serial restoring divider, one quotient bit per cycle.
// Depends on dcsl_pkg; the dividend must be below divisor times 2**DIV_Q_W.
module dcsl_div
   import dcsl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_Q_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W-1:0]   dsr_ff, dsr_in;
   logic [DIV_D_W:0]     trial;
   logic                 fits;

   // One trial subtraction per step.
   assign trial = {rem_ff, quo_ff[DIV_Q_W-1]};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS - 1);
         rem_in  = DIV_D_W'(req.dividend[DIV_N_W-1:DIV_Q_W]);
         quo_in  = req.dividend[DIV_Q_W-1:0];
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_D_W'(trial - {1'b0, dsr_ff}) : trial[DIV_D_W-1:0];
         quo_in = {quo_ff[DIV_Q_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

/* rtl/dcsl_back.sv */
// dcsl_back: sequencer that runs the DC blocker, gain and soft knee on one word.
// Depends on dcsl_pkg; uses dcsl_div through its request and response structs.
module dcsl_back
   import dcsl_pkg::*;
#(
   parameter int CHANNELS = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_empty,
   input  entry_type   q_entry,
   output logic        q_pop,
   input  logic        out_free,
   output logic        out_load,
   output result_type  out_result,
   output div_req_type div_req,
   input  div_rsp_type div_rsp
);

   localparam int ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_MUL   = 11'b000_0000_0010,
      ST_SUM   = 11'b000_0000_0100,
      ST_GAIN  = 11'b000_0000_1000,
      ST_MAG   = 11'b000_0001_0000,
      ST_RECIP = 11'b000_0010_0000,
      ST_FIX   = 11'b000_0100_0000,
      ST_KNEE  = 11'b000_1000_0000,
      ST_DPREP = 11'b001_0000_0000,
      ST_DIV   = 11'b010_0000_0000,
      ST_DONE  = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // Per-channel filter history.
   logic signed [15:0] xprev_ff [CHANNELS];
   logic signed [15:0] xprev_in [CHANNELS];
   logic signed [31:0] yprev_ff [CHANNELS];
   logic signed [31:0] yprev_in [CHANNELS];

   // Working registers of the current word.
   logic signed [15:0] x_ff, x_in;
   logic               ch_ff, ch_in;
   logic signed [47:0] prod_ff, prod_in;
   logic signed [31:0] y_ff, y_in;
   logic signed [39:0] p_ff, p_in;
   logic               neg_ff, neg_in;
   logic [21:0]        m_ff, m_in;
   logic [15:0]        q0_ff, q0_in;
   logic signed [15:0] s_ff, s_in;
   logic [15:0]        over_ff, over_in;
   logic [14:0]        range_ff, range_in;
   logic signed [15:0] res_ff, res_in;

   logic [ChW-1:0]     ch_idx;
   logic signed [15:0] xprev;
   logic signed [31:0] yprev;
   logic signed [47:0] hpf_prod;
   logic signed [32:0] feedback;
   logic signed [33:0] sum;
   logic signed [31:0] y_sat;
   logic signed [39:0] gain_prod;
   logic [39:0]        p_mag;
   logic [44:0]        recip_prod;
   logic [22:0]        q0_times;
   logic [22:0]        gain_rem;
   logic [15:0]        q_fix;
   logic [15:0]        s_mag;
   logic [15:0]        thr16;
   logic [16:0]        lim;
   logic [15:0]        lim16;

   assign ch_idx = ChW'(ch_ff);
   assign xprev  = xprev_ff[ch_idx];
   assign yprev  = yprev_ff[ch_idx];

   // Feedback product y_prev * r, kept wide so nothing wraps.
   assign hpf_prod = 48'(yprev) * 48'($signed({1'b0, cfg.hpf_coef}));

   // Floor shift by 15 and the filter sum, saturated to 32 bits.
   assign feedback = 33'(prod_ff >>> 15);
   assign sum      = 34'(x_ff) - 34'(xprev) + 34'(feedback);
   always_comb begin
      if (!sum[33] && (sum[32:31] != 2'b00)) begin
         y_sat = 32'sh7FFF_FFFF;
      end else if (sum[33] && (sum[32:31] != 2'b11)) begin
         y_sat = 32'sh8000_0000;
      end else begin
         y_sat = sum[31:0];
      end
   end

   // Gain product, then magnitude limited so the quotient stays in 16 bits.
   assign gain_prod = 40'(y_ff) * 40'($signed({1'b0, cfg.headroom}));
   assign p_mag     = p_ff[39] ? 40'(-p_ff) : 40'(p_ff);

   // Division by one hundred: reciprocal estimate, then one correction step.
   assign recip_prod = 45'(m_ff) * 45'(RECIP_MULT);
   assign q0_times   = 23'(q0_ff) * 23'(GAIN_DIVISOR);
   assign gain_rem   = 23'(m_ff) - q0_times;
   assign q_fix      = q0_ff + 16'(gain_rem >= 23'(GAIN_DIVISOR));

   // Soft knee inputs.
   assign s_mag = s_ff[15] ? 16'(-s_ff) : 16'(s_ff);
   assign thr16 = {1'b0, cfg.threshold};

   // Knee output magnitude, capped at the largest positive sample.
   assign lim   = 17'(cfg.threshold) + 17'(div_rsp.quotient);
   assign lim16 = (lim > 17'd32767) ? 16'd32767 : lim[15:0];

   // Divider request for over * range / (range + over).
   assign div_req.start    = (state_ff == ST_DPREP);
   assign div_req.dividend = 31'(31'(over_ff) * 31'(range_ff));
   assign div_req.divisor  = 17'(over_ff) + 17'(range_ff);

   assign q_pop                  = (state_ff == ST_IDLE) && !q_empty;
   assign out_load               = (state_ff == ST_DONE) && out_free;
   assign out_result.sample_out  = res_ff;
   assign out_result.channel_out = ch_ff;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      ch_in    = ch_ff;
      prod_in  = prod_ff;
      y_in     = y_ff;
      p_in     = p_ff;
      neg_in   = neg_ff;
      m_in     = m_ff;
      q0_in    = q0_ff;
      s_in     = s_ff;
      over_in  = over_ff;
      range_in = range_ff;
      res_in   = res_ff;
      for (int i = 0; i < CHANNELS; i++) begin
         xprev_in[i] = xprev_ff[i];
         yprev_in[i] = yprev_ff[i];
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               x_in     = $signed(q_entry.sample);
               ch_in    = q_entry.channel;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = hpf_prod;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            y_in = y_sat;
            for (int i = 0; i < CHANNELS; i++) begin
               if (ch_idx == ChW'(i)) begin
                  xprev_in[i] = x_ff;
                  yprev_in[i] = y_sat;
               end
            end
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            p_in     = gain_prod;
            state_in = ST_MAG;
         end
         ST_MAG: begin
            neg_in   = p_ff[39];
            m_in     = (p_mag > 40'(MAG_CLAMP)) ? MAG_CLAMP : p_mag[21:0];
            state_in = ST_RECIP;
         end
         ST_RECIP: begin
            q0_in    = recip_prod[RECIP_SHIFT +: 16];
            state_in = ST_FIX;
         end
         ST_FIX: begin
            if (neg_ff) begin
               s_in = $signed(16'(17'd0 - {1'b0, q_fix}));
            end else if (q_fix > 16'd32767) begin
               s_in = 16'sd32767;
            end else begin
               s_in = $signed(q_fix);
            end
            state_in = ST_KNEE;
         end
         ST_KNEE: begin
            over_in  = s_mag - thr16;
            range_in = cfg.full_scale - cfg.threshold;
            if (s_mag <= thr16) begin
               res_in   = s_ff;
               state_in = ST_DONE;
            end else if (cfg.full_scale <= cfg.threshold) begin
               // Hard clamp at the threshold.
               res_in   = s_ff[15] ? $signed(16'd0 - thr16) : $signed(thr16);
               state_in = ST_DONE;
            end else begin
               state_in = ST_DPREP;
            end
         end
         ST_DPREP: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               res_in   = s_ff[15] ? $signed(16'd0 - lim16) : $signed(lim16);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < CHANNELS; i++) begin
            xprev_ff[i] <= '0;
            yprev_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         for (int i = 0; i < CHANNELS; i++) begin
            xprev_ff[i] <= xprev_in[i];
            yprev_ff[i] <= yprev_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      ch_ff    <= ch_in;
      prod_ff  <= prod_in;
      y_ff     <= y_in;
      p_ff     <= p_in;
      neg_ff   <= neg_in;
      m_ff     <= m_in;
      q0_ff    <= q0_in;
      s_ff     <= s_in;
      over_ff  <= over_in;
      range_ff <= range_in;
      res_ff   <= res_in;
   end

endmodule

/* rtl/audio_dc_block_soft_limiter.sv */
// audio_dc_block_soft_limiter: per-channel DC blocker, gain and soft-knee limiter.
// The sequencer takes a new word only after the last result is loaded; the soft knee uses a 16-step divider.
// A word runs through the states MUL to KNEE, then DPREP and DIV when the knee divides, then DONE.
// Input words queue two deep ahead of the sequencer; one result register at the output.
// Synchronous active-high reset clears filter history, queue and result valid, and loads configuration defaults.
// Depends on dcsl_pkg, assert_macros.svh and the dcsl_front/queue/div/back modules.
`include "assert_macros.svh"
module audio_dc_block_soft_limiter
   import dcsl_pkg::*;
#(
   parameter int CHANNELS = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input queue side
   input  logic                  push,
   output logic                  full,
   input  logic [SAMPLE_W-1:0]   req_sample_in,
   input  logic                  req_channel,
   // Result queue side
   output logic                  empty,
   input  logic                  pop,
   output logic [SAMPLE_W-1:0]   rsp_sample_out,
   output logic                  rsp_channel_out,
   // Register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type csr_index;
   logic          csr_write;

   logic          q_push;
   entry_type     q_push_entry;
   logic          q_full;
   logic          q_pop;
   entry_type     q_pop_entry;
   logic          q_empty;

   logic          out_load;
   logic          out_free;
   result_type    out_result;
   logic          out_valid_ff, out_valid_in;
   result_type    out_data_ff, out_data_in;

   div_req_type   div_req;
   div_rsp_type   div_rsp;

   // Register port: always ready, written in the access phase.
   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_HPF_COEF:   cfg_in.hpf_coef   = pwdata[COEF_W-1:0];
            REG_HEADROOM:   cfg_in.headroom   = pwdata[GAIN_W-1:0];
            REG_THRESHOLD:  cfg_in.threshold  = pwdata[LEVEL_W-1:0];
            REG_FULL_SCALE: cfg_in.full_scale = pwdata[LEVEL_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_HPF_COEF:   prdata = CSR_DATA_W'(cfg_ff.hpf_coef);
         REG_HEADROOM:   prdata = CSR_DATA_W'(cfg_ff.headroom);
         REG_THRESHOLD:  prdata = CSR_DATA_W'(cfg_ff.threshold);
         REG_FULL_SCALE: prdata = CSR_DATA_W'(cfg_ff.full_scale);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dcsl_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .push      (push),
      .full      (full),
      .sample_in (req_sample_in),
      .channel   (req_channel),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_push_entry)
   );

   dcsl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (q_pop_entry),
      .empty      (q_empty)
   );

   dcsl_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   dcsl_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_entry    (q_pop_entry),
      .q_pop      (q_pop),
      .out_free   (out_free),
      .out_load   (out_load),
      .out_result (out_result),
      .div_req    (div_req),
      .div_rsp    (div_rsp)
   );

   // Result register: the slot frees in the same cycle its word is taken.
   assign out_free = !out_valid_ff || pop;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_data_in  = out_result;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign empty           = !out_valid_ff;
   assign rsp_sample_out  = out_data_ff.sample_out;
   assign rsp_channel_out = out_data_ff.channel_out;

   // A finished word never overwrites a result still waiting to be taken.
   `ASSERT_IMPLIES(a_load_into_free_slot, out_load, !out_valid_ff || pop, "result overwritten")
   // The divider is only started when it is idle.
   `ASSERT_IMPLIES(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted")
   // The sequencer pops a word only when the queue holds one.
   `ASSERT_IMPLIES(a_pop_nonempty, q_pop, !q_empty, "pop from empty queue")
   // After reset the result register is empty and the input queue is not full.
   `ASSERT_IMPLIES(a_reset_empty, $past(reset), empty && !full, "queues not empty after reset")

endmodule
